// File: rtl/sjew_pkg.sv
package sjew_pkg;

  localparam int CELLS      = 4096;
  localparam int K_MAX      = 32;

  localparam int CELL_W     = 12;
  localparam int SLOT_W     = 5;
  localparam int NB_W       = 12;
  localparam int K_REG_W    = 6;
  localparam int THR_W      = 17;
  localparam int CNT_OUT_W  = 6;
  localparam int WEIGHT_W   = 17;
  localparam int FRAC_BITS  = 16;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam int CNT_W      = $clog2(K_MAX + 1);
  localparam int ACC_W      = $clog2(K_MAX * K_MAX + 1);
  localparam int ADDR_W     = $clog2(CELLS * K_MAX);
  localparam int DEN_W      = CNT_W + 2;
  localparam int NUM_W      = CNT_W + FRAC_BITS + 1;

  localparam logic [K_REG_W-1:0]  K_RESET   = K_REG_W'(20);
  localparam logic [THR_W-1:0]    THR_RESET = THR_W'(4369);
  localparam logic [WEIGHT_W-1:0] W_ONE     = WEIGHT_W'(1) << FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_K   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THR = CFG_IDX_W'(1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic             en;
    logic [NB_W-1:0]  val;
    logic [CNT_W-1:0] cnt;
  } tok_t;

endpackage

// File: rtl/snn_jaccard_edge_weight_top.sv
// Shared-nearest-neighbour Jaccard edge weight. Opcode write (tuser 0) stores one neighbour
// index into one slot of one cell's list; out-of-range cells or slots are
// dropped. Opcode query (tuser 1) counts equal entry pairs between the lists of two cells and
// returns s (saturated at k), the Q1.16 weight s/(2k-s) rounded half up, and the kept flag;
// pruned edges give weight 0. A query runs in steps: list b is read into a row of K_MAX
// compare cells one entry per cycle through the single table read port, list a is then
// streamed through the row until its last token leaves the row, and a restoring divider
// spends one cycle per quotient bit. The table holds no reset value: only entries already
// written may be queried. Set k and the prune threshold only while no query is in flight
// and no result is pending.
module snn_jaccard_edge_weight_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sjew_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sjew_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // cell_req[11:0], slot[16:12], neighbor[28:17], other_cell[40:29], zero pad
  input  logic [sjew_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // opcode
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // shared_count[5:0], weight[22:6], zero pad
  output logic [sjew_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // kept
  output logic                              m_axis_tuser_o
);
  import sjew_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOADB  = 3'd1;
  localparam logic [2:0] ST_STREAM = 3'd2;
  localparam logic [2:0] ST_WAIT   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [K_REG_W-1:0]  k_reg_q;
  logic [THR_W-1:0]    thr_q;
  logic [CNT_W-1:0]    k_act;
  logic [CNT_W-1:0]    k_q;
  logic [CELL_W-1:0]   a_q, b_q;
  logic [CNT_W-1:0]    issue_q;
  logic [ACC_W-1:0]    acc_q;
  logic [CNT_W-1:0]    got_q;
  logic [CNT_W-1:0]    s_q;
  logic [WEIGHT_W-1:0] w_q;

  logic [CELL_W-1:0]   in_cell;
  logic [SLOT_W-1:0]   in_slot;
  logic [NB_W-1:0]     in_nb;
  logic [CELL_W-1:0]   in_other;
  logic                in_xfer;
  logic                start_q_pulse;
  logic                bad_query;

  logic [NB_W-1:0]     mem_q [CELLS*K_MAX];
  logic                mem_we;
  logic [ADDR_W-1:0]   wr_addr;
  logic                rd_en;
  logic [CELL_W-1:0]   rd_cell;
  logic [ADDR_W-1:0]   rd_addr;
  logic [NB_W-1:0]     rdata_q;
  logic                rd_b_q, rd_a_q;

  logic [NB_W-1:0]     b_val [K_MAX];
  logic                b_vld [K_MAX];
  tok_t                tok   [K_MAX];
  tok_t                tok_in;

  logic [CNT_W-1:0]    s_sat;
  logic [CNT_W:0]      d_val;
  logic [DEN_W-1:0]    den;
  logic [NUM_W-1:0]    num;
  logic                div_start;
  logic                div_done;
  logic [NUM_W-1:0]    quo;

  logic                out_load;
  logic                kept_calc;
  logic                m_valid_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;
  logic [WEIGHT_W-1:0] out_w_q;
  logic                out_kept_q;

  assign in_cell  = s_axis_tdata_i[CELL_W-1:0];
  assign in_slot  = s_axis_tdata_i[CELL_W +: SLOT_W];
  assign in_nb    = s_axis_tdata_i[CELL_W+SLOT_W +: NB_W];
  assign in_other = s_axis_tdata_i[CELL_W+SLOT_W+NB_W +: CELL_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign bad_query     = (32'(in_cell) >= CELLS) || (32'(in_other) >= CELLS);
  assign start_q_pulse = in_xfer && (s_axis_tuser_i == OP_QUERY) && !bad_query;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_reg_q <= K_RESET;
      thr_q   <= THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_K:   k_reg_q <= cfg_wdata_i[K_REG_W-1:0];
        REG_THR: thr_q   <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (k_reg_q == '0) begin
      k_act = CNT_W'(1);
    end else if (32'(k_reg_q) > K_MAX) begin
      k_act = CNT_W'(K_MAX);
    end else begin
      k_act = CNT_W'(k_reg_q);
    end
  end

  // neighbour table
  assign mem_we  = in_xfer && (s_axis_tuser_i == OP_WRITE) && (32'(in_cell) < CELLS) &&
                   (32'(in_slot) < K_MAX);
  assign wr_addr = ADDR_W'(in_cell) * ADDR_W'(K_MAX) + ADDR_W'(in_slot);
  assign rd_en   = (state_q == ST_LOADB) || (state_q == ST_STREAM);
  assign rd_cell = (state_q == ST_LOADB) ? b_q : a_q;
  assign rd_addr = ADDR_W'(rd_cell) * ADDR_W'(K_MAX) + ADDR_W'(issue_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= in_nb;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // compare row
  always_comb begin
    tok_in.en  = rd_a_q;
    tok_in.val = rdata_q;
    tok_in.cnt = '0;
  end

  for (genvar g = 0; g < K_MAX; g++) begin : g_cell
    if (g == 0) begin : g_head
      sjew_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .clear_i (start_q_pulse),
        .shift_i (rd_b_q),
        .b_i     (rdata_q),
        .bvld_i  (1'b1),
        .b_o     (b_val[g]),
        .bvld_o  (b_vld[g]),
        .tok_i   (tok_in),
        .tok_o   (tok[g])
      );
    end else begin : g_body
      sjew_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .clear_i (start_q_pulse),
        .shift_i (rd_b_q),
        .b_i     (b_val[g-1]),
        .bvld_i  (b_vld[g-1]),
        .b_o     (b_val[g]),
        .bvld_o  (b_vld[g]),
        .tok_i   (tok[g-1]),
        .tok_o   (tok[g])
      );
    end
  end

  // weight
  assign s_sat = (acc_q >= ACC_W'(k_q)) ? k_q : CNT_W'(acc_q);
  assign d_val = {k_q, 1'b0} - {1'b0, s_sat};
  assign den   = {d_val, 1'b0};
  assign num   = {s_sat, {(FRAC_BITS+1){1'b0}}} + NUM_W'(d_val);
  assign div_start = (state_q == ST_WAIT) && (got_q == k_q) && (s_sat != '0) &&
                     (s_sat != k_q);

  sjew_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign out_load  = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready_i);
  assign kept_calc = (s_q != '0) && (w_q >= thr_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (s_axis_tuser_i == OP_QUERY)) begin
          state_d = bad_query ? ST_FIN : ST_LOADB;
        end
      end
      ST_LOADB: begin
        if (issue_q == k_q - CNT_W'(1)) state_d = ST_STREAM;
      end
      ST_STREAM: begin
        if (issue_q == k_q - CNT_W'(1)) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (got_q == k_q) state_d = div_start ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issue_q   <= '0;
      got_q     <= '0;
      acc_q     <= '0;
      rd_b_q    <= 1'b0;
      rd_a_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_b_q  <= (state_q == ST_LOADB);
      rd_a_q  <= (state_q == ST_STREAM);
      if (start_q_pulse) begin
        issue_q <= '0;
        got_q   <= '0;
        acc_q   <= '0;
      end else begin
        if (rd_en) begin
          issue_q <= (issue_q == k_q - CNT_W'(1)) ? '0 : issue_q + CNT_W'(1);
        end
        if (tok[K_MAX-1].en) begin
          got_q <= got_q + CNT_W'(1);
          acc_q <= acc_q + ACC_W'(tok[K_MAX-1].cnt);
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && (s_axis_tuser_i == OP_QUERY)) begin
      a_q <= in_cell;
      b_q <= in_other;
      k_q <= k_act;
      s_q <= '0;
      w_q <= '0;
    end
    if ((state_q == ST_WAIT) && (got_q == k_q)) begin
      s_q <= s_sat;
      w_q <= (s_sat == k_q) ? W_ONE : '0;
    end
    if ((state_q == ST_DIV) && div_done) begin
      w_q <= quo[WEIGHT_W-1:0];
    end
    if (out_load) begin
      out_cnt_q  <= CNT_OUT_W'(s_q);
      out_w_q    <= kept_calc ? w_q : '0;
      out_kept_q <= kept_calc;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-CNT_OUT_W-WEIGHT_W){1'b0}}, out_w_q, out_cnt_q};
  assign m_axis_tuser_o  = out_kept_q;

  a_kept_weight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && out_kept_q |-> (out_w_q >= thr_q) && (out_w_q != '0) && (out_cnt_q != '0))
    else $error("kept edge with weight below threshold");

  a_pruned_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !out_kept_q |-> out_w_q == '0)
    else $error("pruned edge with non-zero weight");

  a_token_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) && (state_q != ST_FIN) |-> got_q <= k_q)
    else $error("more row tokens than list entries");

  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside final state");

endmodule

// File: rtl/sjew_cell.sv
module sjew_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       shift_i,
  input  logic [sjew_pkg::NB_W-1:0]  b_i,
  input  logic                       bvld_i,
  output logic [sjew_pkg::NB_W-1:0]  b_o,
  output logic                       bvld_o,
  input  sjew_pkg::tok_t             tok_i,
  output sjew_pkg::tok_t             tok_o
);
  import sjew_pkg::*;

  logic [NB_W-1:0]  b_q;
  logic             bvld_q;
  logic             tok_en_q;
  logic [NB_W-1:0]  tok_val_q;
  logic [CNT_W-1:0] tok_cnt_q;
  logic             hit;

  assign hit = tok_i.en && bvld_q && (tok_i.val == b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q   <= 1'b0;
      tok_en_q <= 1'b0;
    end else begin
      if (clear_i) begin
        bvld_q <= 1'b0;
      end else if (shift_i) begin
        bvld_q <= bvld_i;
      end
      tok_en_q <= tok_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      b_q <= b_i;
    end
    tok_val_q <= tok_i.val;
    tok_cnt_q <= tok_i.cnt + CNT_W'(hit);
  end

  always_comb begin
    tok_o.en  = tok_en_q;
    tok_o.val = tok_val_q;
    tok_o.cnt = tok_cnt_q;
  end

  assign b_o    = b_q;
  assign bvld_o = bvld_q;

endmodule

// File: rtl/sjew_div.sv
module sjew_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sjew_pkg::NUM_W-1:0]  num_i,
  input  logic [sjew_pkg::DEN_W-1:0]  den_i,
  output logic                        done_o,
  output logic [sjew_pkg::NUM_W-1:0]  quo_o
);
  import sjew_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [NUM_W-1:0]  num_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(NUM_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      num_q <= num_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: tb/testbench.sv
module testbench;
  import sjew_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 160;
  localparam int LONG_HOLD   = 1500;
  localparam int POOL_N      = 10;

  typedef struct packed {
    logic              opcode;
    logic [CELL_W-1:0] cell_no;
    logic [SLOT_W-1:0] slot;
    logic [NB_W-1:0]   nb;
    logic [CELL_W-1:0] other;
  } op_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] shared;
    logic [WEIGHT_W-1:0]  weight;
    logic                 kept;
  } link_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  // predictor state
  logic [NB_W-1:0]    nb_table [CELLS*K_MAX];
  logic [K_REG_W-1:0] k_setting = K_RESET;
  logic [THR_W-1:0]   thr_setting = THR_RESET;

  // generator state
  bit                 nb_written [CELLS*K_MAX];
  logic [CELL_W-1:0]  pool [POOL_N];
  logic [NB_W-1:0]    list_base;
  bit                 quiet = 1'b0;

  op_t   ops_to_send [$];
  link_t pending_links [$];
  op_t   on_bus;
  int    gap_left = 0;
  int    hold_left = 0;
  int    stall_left = 0;
  int    links_seen = 0;
  int    mismatches = 0;
  int    idle_cycles = 0;

  snn_jaccard_edge_weight_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int k_used();
    if (k_setting == 0) return 1;
    if (k_setting > K_MAX) return K_MAX;
    return int'(k_setting);
  endfunction

  function automatic link_t predict_link(logic [CELL_W-1:0] a, logic [CELL_W-1:0] b);
    link_t r;
    int k;
    int s;
    int d;
    int w;
    k = k_used();
    s = 0;
    w = 0;
    for (int i = 0; i < k; i++)
      for (int j = 0; j < k; j++)
        if (nb_table[int'(a)*K_MAX + i] == nb_table[int'(b)*K_MAX + j]) s++;
    if (s >= k) begin
      s = k;
      w = 65536;
    end else if (s > 0) begin
      d = 2*k - s;
      w = ((s << 17) + d) / (2*d);
    end
    r.kept = (s > 0) && (w >= int'(thr_setting));
    if (!r.kept) w = 0;
    r.shared = s[CNT_OUT_W-1:0];
    r.weight = w[WEIGHT_W-1:0];
    return r;
  endfunction

  function automatic int draw_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic bit list_ready(logic [CELL_W-1:0] cell_no);
    for (int i = 0; i < k_used(); i++)
      if (!nb_written[int'(cell_no)*K_MAX + i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void push_write(logic [CELL_W-1:0] cell_no, logic [SLOT_W-1:0] slot,
                                     logic [NB_W-1:0] nb);
    op_t o;
    o.opcode  = OP_WRITE;
    o.cell_no = cell_no;
    o.slot    = slot;
    o.nb      = nb;
    o.other   = CELL_W'($urandom_range(0, CELLS-1));
    nb_written[int'(cell_no)*K_MAX + int'(slot)] = 1'b1;
    ops_to_send.insert(ops_to_send.size(), o);
  endfunction

  function automatic void push_query(logic [CELL_W-1:0] a, logic [CELL_W-1:0] b);
    op_t o;
    o.opcode  = OP_QUERY;
    o.cell_no = a;
    o.slot    = SLOT_W'($urandom_range(0, K_MAX-1));
    o.nb      = NB_W'($urandom_range(0, 4095));
    o.other   = b;
    ops_to_send.insert(ops_to_send.size(), o);
  endfunction

  // fills slots 0..k-1 of one cell, values clustered so that lists overlap
  function automatic int push_list(logic [CELL_W-1:0] cell_no);
    int span;
    logic [NB_W-1:0] base;
    case ($urandom_range(0, 3))
      0: span = 1;
      1: span = k_used();
      2: span = 3 * k_used();
      default: span = 4095;
    endcase
    base = ($urandom_range(0, 3) != 0) ? list_base : NB_W'($urandom_range(0, 4095));
    for (int i = 0; i < k_used(); i++)
      push_write(cell_no, SLOT_W'(i), NB_W'(int'(base) + $urandom_range(0, span)));
    return k_used();
  endfunction

  function automatic void plan_random(int n);
    int made;
    int r;
    logic [CELL_W-1:0] a;
    logic [CELL_W-1:0] b;
    made = 0;
    list_base = NB_W'($urandom_range(0, 4095));
    while (made < n) begin
      r = $urandom_range(0, 99);
      a = pool[$urandom_range(0, POOL_N-1)];
      b = pool[$urandom_range(0, POOL_N-1)];
      if (r < 20) begin
        made += push_list(a);
      end else if (r < 32) begin
        if ($urandom_range(0, 1)) a = CELL_W'($urandom_range(0, CELLS-1));
        push_write(a, SLOT_W'($urandom_range(0, K_MAX-1)), NB_W'($urandom_range(0, 4095)));
        made++;
      end else if (!list_ready(a)) begin
        made += push_list(a);
      end else if (!list_ready(b)) begin
        made += push_list(b);
      end else begin
        push_query(a, b);
        made++;
      end
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    if (idx == REG_K) k_setting = val[K_REG_W-1:0];
    else thr_setting = val[THR_W-1:0];
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (ops_to_send.size() != 0 || s_axis_tvalid || pending_links.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [K_REG_W-1:0] k, input logic [THR_W-1:0] thr,
                           input int n, input bit q);
    wait_idle();
    quiet = q;
    write_reg(REG_K, CFG_DATA_W'(k));
    write_reg(REG_THR, thr);
    plan_random(n);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready_o) begin
        if (on_bus.opcode == OP_WRITE)
          nb_table[int'(on_bus.cell_no)*K_MAX + int'(on_bus.slot)] = on_bus.nb;
        else
          pending_links.insert(pending_links.size(),
                               predict_link(on_bus.cell_no, on_bus.other));
      end
      if (!s_axis_tvalid || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (ops_to_send.size() != 0) begin
          on_bus = ops_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'b0, on_bus.other, on_bus.nb, on_bus.slot, on_bus.cell_no};
          s_axis_tuser  <= on_bus.opcode;
          gap_left = quiet ? 0 : draw_idle();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and result check
  always @(posedge clk_i) begin
    link_t want;
    link_t got;
    bit    took;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      took = m_axis_tvalid_o && m_axis_tready;
      if (took) begin
        got.shared = m_axis_tdata_o[5:0];
        got.weight = m_axis_tdata_o[22:6];
        got.kept   = m_axis_tuser_o;
        links_seen++;
        if (pending_links.size() == 0) begin
          $error("result transfer with no query pending");
          mismatches++;
        end else begin
          want = pending_links.pop_front();
          if (got.shared !== want.shared) begin
            $error("shared_count: expected %0d, got %0d", want.shared, got.shared);
            mismatches++;
          end
          if (got.weight !== want.weight) begin
            $error("weight: expected %0d, got %0d", want.weight, got.weight);
            mismatches++;
          end
          if (got.kept !== want.kept) begin
            $error("kept: expected %0d, got %0d", want.kept, got.kept);
            mismatches++;
          end
        end
      end
      // long back-pressure so the block fills up and stalls its input
      if (took && (links_seen == 30 || links_seen == 200)) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) stall_left = draw_idle();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready) || cfg_we)
        idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pool[0] = '0;
    pool[1] = CELL_W'(CELLS-1);
    for (int i = 2; i < POOL_N; i++) pool[i] = CELL_W'($urandom_range(0, CELLS-1));
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: k = 2, threshold just above one third
    write_reg(REG_K, CFG_DATA_W'(2));
    write_reg(REG_THR, CFG_DATA_W'(21846));
    push_write(12'd0, 5'd0, 12'd0);
    push_write(12'd0, 5'd1, 12'd4095);
    push_write(12'd4095, 5'd0, 12'd4095);
    push_write(12'd4095, 5'd1, 12'd4095);
    push_query(12'd0, 12'd4095);       // repeated neighbours, saturates at k
    push_write(12'd1, 5'd0, 12'd7);
    push_write(12'd1, 5'd1, 12'd8);
    push_query(12'd0, 12'd1);          // nothing shared
    push_write(12'd2, 5'd0, 12'd0);
    push_write(12'd2, 5'd1, 12'd9);
    push_query(12'd0, 12'd2);          // one shared, pruned
    push_write(12'd3, 5'd31, 12'd4095);
    push_query(12'd4095, 12'd4095);
    push_query(12'd2, 12'd0);

    run_phase(6'd20, 17'd4369, 150, 1'b0);
    run_phase(6'd1, 17'd65536, 150, 1'b0);
    run_phase(6'd32, 17'd0, 150, 1'b1);
    run_phase(6'd0, 17'd131071, 150, 1'b0);
    run_phase(6'd63, 17'd30000, 150, 1'b0);
    run_phase(6'd7, 17'd12000, 150, 1'b0);
    wait_idle();

    if (mismatches == 0 && pending_links.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: snn_jaccard_edge_weight_top.f
rtl/sjew_pkg.sv
rtl/sjew_cell.sv
rtl/sjew_div.sv
rtl/snn_jaccard_edge_weight_top.sv
tb/testbench.sv
